// File: hdl/ptl_pkg.sv
// shared types and constants of the priority task list
package ptl_pkg;
  localparam int TASKS = 32;
  localparam int SW = $clog2(TASKS);
  localparam int MAX_OUT = 32;
  localparam int CW = $clog2(MAX_OUT + 1);

  localparam logic [2:0] K_CREATE = 3'd0;
  localparam logic [2:0] K_KILL = 3'd1;
  localparam logic [2:0] K_CHANGE = 3'd2;
  localparam logic [2:0] K_PCHECK = 3'd3;
  localparam logic [2:0] K_RUN = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD = 2'd2;
  localparam logic [1:0] ST_PZERO = 2'd3;

  localparam logic [15:0] HEAD_PRIO = 16'h0000;

  typedef struct packed {
    logic [2:0]  kind;
    logic [4:0]  slot;
    logic [15:0] prio;
    logic [7:0]  handler;
    logic [4:0]  parent;
    logic        has_parent;
    logic        slot_ok;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  slot;
    logic [7:0]  handler;
    logic [15:0] prio;
    logic        parent_dead;
    logic        last;
  } res_t;
endpackage

// File: hdl/ptl_front.sv
// front end: accepts words, drops unknown kinds, checks slot range, queues commands
module ptl_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [2:0]    in_kind,
  input  logic [4:0]    in_slot,
  input  logic [15:0]   in_priority_req,
  input  logic [7:0]    in_handler,
  input  logic [4:0]    in_parent_slot,
  input  logic          in_has_parent,
  output ptl_pkg::cmd_t q_cmd,
  output logic          q_valid,
  input  logic          q_pop
);
  import ptl_pkg::*;

  cmd_t q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic wp_r, rp_r;
  logic push;
  cmd_t c;

  always_comb begin
    c.kind = in_kind;
    c.slot = in_slot;
    c.prio = in_priority_req;
    c.handler = in_handler;
    c.parent = in_parent_slot;
    c.has_parent = in_has_parent;
    c.slot_ok = ({1'b0, in_slot} < 6'(TASKS));
  end

  assign in_ready = (cnt_r != 2'd2);
  // unknown kinds are swallowed here
  assign push = in_valid && in_ready && (in_kind <= K_RUN);
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd = q_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r <= 1'b0;
      rp_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= c;
  end
endmodule

// File: hdl/ptl_back.sv
// back end: sequencer over the slot tables
module ptl_back (
  input  logic          clk,
  input  logic          rst_n,
  input  ptl_pkg::cmd_t q_cmd,
  input  logic          q_valid,
  output logic          q_pop,
  output ptl_pkg::res_t res,
  output logic          res_valid,
  input  logic          res_ready
);
  import ptl_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_WALK  = 6'b000100,
    S_LINK  = 6'b001000,
    S_RUN   = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t state_r;
  logic [TASKS-1:0] used_r, ppres_r;
  logic [15:0] prio_r [TASKS];
  logic [7:0] hand_r [TASKS];
  logic [SW-1:0] next_r [TASKS];
  logic [SW-1:0] prev_r [TASKS];
  logic [4:0] plink_r [TASKS];

  cmd_t cmd_r;
  logic [SW-1:0] id_r, cur_r;
  logic [CW-1:0] k_r;
  res_t res_r;
  logic rv_r;

  logic [SW-1:0] sidx, nx;
  logic [SW:0] free_id;
  logic pl_live;
  logic run_last;
  logic bad_slot;
  logic [1:0] first_st;
  logic first_pd, first_done;

  assign res = res_r;
  assign res_valid = rv_r;
  assign sidx = cmd_r.slot[SW-1:0];
  assign nx = next_r[cur_r];
  assign pl_live = ({1'b0, plink_r[sidx]} < 6'(TASKS)) ?
                   used_r[plink_r[sidx][SW-1:0]] : 1'b0;
  assign run_last = (nx == '0) || (k_r + 1'b1 >= CW'(MAX_OUT));

  // lowest free slot, priority encoder
  always_comb begin
    free_id = (SW+1)'(TASKS);
    for (int i = TASKS - 1; i >= 0; i--) begin
      if (!used_r[i]) free_id = (SW+1)'(i);
    end
  end

  // commands that finish at once with their status
  always_comb begin
    bad_slot = !q_cmd.slot_ok || !used_r[q_cmd.slot[SW-1:0]];
    first_st = ST_OK;
    first_pd = 1'b0;
    first_done = 1'b0;
    unique case (q_cmd.kind)
      K_CREATE: begin
        if (q_cmd.prio == HEAD_PRIO) begin
          first_st = ST_PZERO; first_done = 1'b1;
        end
      end
      K_KILL: begin
        if (q_cmd.slot == '0 || bad_slot) begin
          first_st = ST_BAD; first_done = 1'b1;
        end
      end
      K_CHANGE: begin
        first_done = 1'b1;
        if (bad_slot) first_st = ST_BAD;
      end
      K_PCHECK: begin
        if (bad_slot) begin
          first_st = ST_BAD; first_pd = 1'b1; first_done = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign q_pop = (state_r == S_IDLE) && q_valid && !rv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rv_r <= 1'b0;
      used_r <= TASKS'(1);
      ppres_r <= '0;
      next_r[0] <= '0;
      prev_r[0] <= '0;
      prio_r[0] <= HEAD_PRIO;
      hand_r[0] <= '0;
    end else begin
      if (rv_r && res_ready && state_r != S_RUN) rv_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            cmd_r <= q_cmd;
            res_r <= '{status: first_st, slot: '0, handler: '0, prio: '0,
                       parent_dead: first_pd, last: 1'b1};
            rv_r <= first_done;
            cur_r <= '0;
            k_r <= '0;
            if (q_cmd.kind == K_CHANGE && !bad_slot)
              hand_r[q_cmd.slot[SW-1:0]] <= q_cmd.handler;
            if (!first_done) begin
              unique case (q_cmd.kind)
                K_CREATE: state_r <= S_SCAN;
                K_KILL: state_r <= S_LINK;
                K_PCHECK: state_r <= S_EMIT;
                default: state_r <= S_RUN;
              endcase
            end
          end
        end
        S_SCAN: begin
          if (free_id[SW]) begin
            res_r.status <= ST_FULL; rv_r <= 1'b1; state_r <= S_IDLE;
          end else begin
            id_r <= free_id[SW-1:0];
            state_r <= S_WALK;
          end
        end
        S_WALK: begin
          // advance while next entry has priority <= new one
          if (nx == '0 || prio_r[nx] > cmd_r.prio) begin
            hand_r[id_r] <= cmd_r.handler;
            prio_r[id_r] <= cmd_r.prio;
            plink_r[id_r] <= cmd_r.parent;
            ppres_r[id_r] <= cmd_r.has_parent;
            prev_r[id_r] <= cur_r;
            next_r[id_r] <= nx;
            next_r[cur_r] <= id_r;
            prev_r[nx] <= id_r;
            used_r[id_r] <= 1'b1;
            res_r.slot <= 5'(id_r);
            rv_r <= 1'b1;
            state_r <= S_IDLE;
          end else cur_r <= nx;
        end
        S_LINK: begin
          next_r[prev_r[sidx]] <= next_r[sidx];
          prev_r[next_r[sidx]] <= prev_r[sidx];
          used_r[sidx] <= 1'b0;
          rv_r <= 1'b1;
          state_r <= S_IDLE;
        end
        S_EMIT: begin
          res_r.parent_dead <= !(ppres_r[sidx] && pl_live);
          rv_r <= 1'b1;
          state_r <= S_IDLE;
        end
        S_RUN: begin
          if (!rv_r || res_ready) begin
            res_r <= '{status: ST_OK, slot: 5'(cur_r), handler: hand_r[cur_r],
                       prio: prio_r[cur_r], parent_dead: 1'b0, last: run_last};
            rv_r <= 1'b1;
            k_r <= k_r + 1'b1;
            cur_r <= nx;
            if (run_last) state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// File: hdl/priority_task_list_top.sv
// Priority task list: a 32-slot pool kept as a ring sorted by priority with
// slot 0 as fixed head. A front stage accepts one word per cycle, while its
// two-entry command queue has room; the back sequencer handles one command at a time.
// Kill, change and parent check need no walk; create walks the ring one entry
// at a time to its place; run emits one word per cycle while the receiver is ready, one
// per linked entry. The back end's ring walk over the link table sets the rate.
module priority_task_list_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_kind,
  input  logic [4:0]  in_slot,
  input  logic [15:0] in_priority_req,
  input  logic [7:0]  in_handler,
  input  logic [4:0]  in_parent_slot,
  input  logic        in_has_parent,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [4:0]  out_result_slot,
  output logic [7:0]  out_result_handler,
  output logic [15:0] out_result_priority,
  output logic        out_parent_dead,
  output logic        out_last
);
  import ptl_pkg::*;

  cmd_t q_cmd;
  logic q_valid, q_pop;
  res_t res;

  ptl_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_kind, .in_slot, .in_priority_req,
    .in_handler, .in_parent_slot, .in_has_parent, .q_cmd, .q_valid, .q_pop
  );

  ptl_back u_back (
    .clk, .rst_n, .q_cmd, .q_valid, .q_pop, .res,
    .res_valid(out_valid), .res_ready(out_ready)
  );

  assign out_status = res.status;
  assign out_result_slot = res.slot;
  assign out_result_handler = res.handler;
  assign out_result_priority = res.prio;
  assign out_parent_dead = res.parent_dead;
  assign out_last = res.last;
endmodule

// File: tb/priority_task_list_checker.sv
// checker for the priority task list: watches both channels, predicts and compares words
`timescale 1ns / 1ps
module priority_task_list_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  in_kind,
  input  logic [4:0]  in_slot,
  input  logic [15:0] in_priority_req,
  input  logic [7:0]  in_handler,
  input  logic [4:0]  in_parent_slot,
  input  logic        in_has_parent,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_status,
  input  logic [4:0]  out_result_slot,
  input  logic [7:0]  out_result_handler,
  input  logic [15:0] out_result_priority,
  input  logic        out_parent_dead,
  input  logic        out_last,
  output int          fail_count,
  output int          pending_words,
  output int          words_seen
);
  import ptl_pkg::*;

  logic          used [TASKS];
  logic [15:0]   prio_of [TASKS];
  logic [7:0]    hdl_of [TASKS];
  logic [SW-1:0] nxt_of [TASKS];
  logic [SW-1:0] prv_of [TASKS];
  logic [4:0]    par_of [TASKS];
  logic          haspar [TASKS];
  res_t          expected_words [$];

  assign pending_words = expected_words.size();

  function automatic res_t mk(logic [1:0] st, logic [4:0] sl, logic [7:0] h,
                              logic [15:0] p, logic pd, logic l);
    res_t r;
    r.status = st; r.slot = sl; r.handler = h; r.prio = p;
    r.parent_dead = pd; r.last = l;
    return r;
  endfunction

  function automatic logic alive(logic [4:0] s);
    return (s < TASKS) && used[s];
  endfunction

  task automatic apply_command(logic [2:0] k, logic [4:0] s, logic [15:0] p,
                               logic [7:0] h, logic [4:0] ps, logic hp);
    int id, pv, nx, cnt;
    logic dead;
    case (k)
      K_CREATE: begin
        if (p == HEAD_PRIO) begin
          expected_words.push_back(mk(ST_PZERO, 0, 0, 0, 0, 1));
        end else begin
          id = TASKS;
          for (int i = TASKS - 1; i >= 0; i--) if (!used[i]) id = i;
          if (id == TASKS) begin
            expected_words.push_back(mk(ST_FULL, 0, 0, 0, 0, 1));
          end else begin
            pv = 0;
            for (int n = 0; n < TASKS; n++) begin
              nx = nxt_of[pv];
              if (nx == 0 || prio_of[nx] > p) break;
              pv = nx;
            end
            nx = nxt_of[pv];
            hdl_of[id] = h; prio_of[id] = p; par_of[id] = ps; haspar[id] = hp;
            prv_of[id] = SW'(pv); nxt_of[id] = SW'(nx);
            nxt_of[pv] = SW'(id); prv_of[nx] = SW'(id);
            used[id] = 1;
            expected_words.push_back(mk(ST_OK, 5'(id), 0, 0, 0, 1));
          end
        end
      end
      K_KILL: begin
        if (s == 0 || !alive(s)) begin
          expected_words.push_back(mk(ST_BAD, 0, 0, 0, 0, 1));
        end else begin
          nxt_of[prv_of[s]] = nxt_of[s];
          prv_of[nxt_of[s]] = prv_of[s];
          used[s] = 0;
          expected_words.push_back(mk(ST_OK, 0, 0, 0, 0, 1));
        end
      end
      K_CHANGE: begin
        if (!alive(s)) begin
          expected_words.push_back(mk(ST_BAD, 0, 0, 0, 0, 1));
        end else begin
          hdl_of[s] = h;
          expected_words.push_back(mk(ST_OK, 0, 0, 0, 0, 1));
        end
      end
      K_PCHECK: begin
        if (!alive(s)) begin
          expected_words.push_back(mk(ST_BAD, 0, 0, 0, 1, 1));
        end else begin
          dead = !(haspar[s] && alive(par_of[s]));
          expected_words.push_back(mk(ST_OK, 0, 0, 0, dead, 1));
        end
      end
      K_RUN: begin
        pv = 0;
        cnt = 0;
        forever begin
          nx = nxt_of[pv];
          dead = (nx == 0) || (cnt + 1 >= MAX_OUT);
          expected_words.push_back(mk(ST_OK, 5'(pv), hdl_of[pv], prio_of[pv], 0, dead));
          cnt++;
          if (dead) break;
          pv = nx;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    res_t got, want;
    if (!rst_n) begin
      for (int i = 0; i < TASKS; i++) begin
        used[i] = (i == 0); prio_of[i] = 0; hdl_of[i] = 0; nxt_of[i] = 0;
        prv_of[i] = 0; par_of[i] = 0; haspar[i] = 0;
      end
      expected_words.delete();
      fail_count <= 0;
      words_seen <= 0;
    end else begin
      if (in_valid && in_ready)
        apply_command(in_kind, in_slot, in_priority_req, in_handler,
                      in_parent_slot, in_has_parent);
      if (out_valid && out_ready) begin
        got = mk(out_status, out_result_slot, out_result_handler,
                 out_result_priority, out_parent_dead, out_last);
        words_seen <= words_seen + 1;
        if (expected_words.size() == 0) begin
          if (fail_count < 10) $display("unexpected word %p", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            if (fail_count < 10) $display("mismatch: expected %p got %p", want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// File: tb/priority_task_list_top_test.sv
// top of the priority task list testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module priority_task_list_top_test;
  import ptl_pkg::*;
  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [2:0] in_kind = 0;
  logic [4:0] in_slot = 0;
  logic [15:0] in_priority_req = 0;
  logic [7:0] in_handler = 0;
  logic [4:0] in_parent_slot = 0;
  logic in_has_parent = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [1:0] out_status;
  logic [4:0] out_result_slot;
  logic [7:0] out_result_handler;
  logic [15:0] out_result_priority;
  logic out_parent_dead;
  logic out_last;
  int fail_count, pending_words, words_seen;
  int commands_sent = 0;
  bit calm_in = 0, calm_out = 0;

  always #5 clk = ~clk;

  priority_task_list_top i_dut (.*);
  priority_task_list_checker i_chk (.*);

  // valid stays up between back-to-back words, drops only for a gap
  task automatic send(logic [2:0] k, logic [4:0] s, logic [15:0] p, logic [7:0] h,
                      logic [4:0] ps, logic hp);
    int gap;
    gap = calm_in ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1; in_kind <= k; in_slot <= s; in_priority_req <= p;
    in_handler <= h; in_parent_slot <= ps; in_has_parent <= hp;
    do @(posedge clk); while (!in_ready);
    commands_sent++;
  endtask

  task automatic send_random();
    int r;
    logic [2:0] k;
    logic [15:0] p;
    r = $urandom_range(0, 99);
    if (r < 35) k = K_CREATE;
    else if (r < 60) k = K_KILL;
    else if (r < 72) k = K_CHANGE;
    else if (r < 85) k = K_PCHECK;
    else if (r < 97) k = K_RUN;
    else k = 3'($urandom_range(5, 7));
    case ($urandom_range(0, 5))
      0: p = 0;
      1: p = 16'hffff;
      2: p = 16'($urandom_range(1, 8));
      default: p = 16'($urandom);
    endcase
    send(k, 5'($urandom), p, 8'($urandom), 5'($urandom), 1'($urandom));
  endtask

  // receiver stalls, with calm stretches
  always @(posedge clk) begin
    int stall;
    if (!rst_n) begin
      out_ready <= 0;
      stall = 0;
    end else if (stall > 0) begin
      stall--;
      out_ready <= 0;
    end else if (out_valid && out_ready) begin
      stall = calm_out ? 0 : $urandom_range(0, 13);
      out_ready <= (stall == 0);
    end else begin
      out_ready <= 1;
    end
  end

  initial begin
    #20_000_000;
    $display("FAIL priority_task_list_top");
    $finish;
  end

  initial begin
    int wait_cycles;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: special cases and field extremes
    send(K_RUN, 0, 0, 0, 0, 0);
    send(K_CREATE, 0, HEAD_PRIO, 8'h11, 0, 0);
    send(K_KILL, 0, 0, 0, 0, 0);
    send(K_KILL, 5'd31, 0, 0, 0, 0);
    send(K_CHANGE, 0, 0, 8'hff, 0, 0);
    send(K_PCHECK, 5'd7, 0, 0, 0, 0);
    send(K_CREATE, 0, 16'hffff, 8'haa, 5'd31, 1);
    send(K_CREATE, 0, 16'd1, 8'h55, 5'd1, 1);
    send(K_CREATE, 0, 16'd1, 8'h01, 5'd0, 0);
    send(K_PCHECK, 5'd1, 0, 0, 0, 0);
    send(K_PCHECK, 5'd2, 0, 0, 0, 0);
    send(K_PCHECK, 5'd3, 0, 0, 0, 0);
    send(K_RUN, 5'd31, 16'hffff, 8'hff, 5'd31, 1);
    send(K_KILL, 5'd1, 0, 0, 0, 0);
    send(K_PCHECK, 5'd2, 0, 0, 0, 0);
    send(3'd7, 5'd31, 16'hffff, 8'hff, 5'd31, 1);
    // fill the pool to report full
    for (int i = 0; i < 32; i++)
      send(K_CREATE, 0, 16'($urandom_range(1, 4)), 8'($urandom), 5'($urandom), 1);
    send(K_RUN, 0, 0, 0, 0, 0);
    for (int i = 0; i < 300; i++) begin
      if (i % 60 == 0) begin
        calm_in = ($urandom_range(0, 2) == 0);
        calm_out = ($urandom_range(0, 2) == 0);
      end
      send_random();
    end
    in_valid <= 0;
    wait_cycles = 0;
    while (pending_words != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (60) @(posedge clk);
    $display("ran %0d commands, %0d result words checked", commands_sent, words_seen);
    if (fail_count == 0 && pending_words == 0)
      $display("PASS priority_task_list_top");
    else
      $display("FAIL priority_task_list_top");
    $finish;
  end
endmodule
